// ----- rtl/bde_pkg.sv -----
// Package for the bitmap draw engine: request codes, the queued command type and shared widths.
// Depends on nothing; all other files but bde_ram and bde_div use it by scoped names.
package bde_pkg;

    localparam int unsigned CoordW = 16;
    localparam int unsigned ColorW = 32;
    localparam int unsigned RegW   = 9;

    typedef enum logic [2:0] {
        REQ_BOX    = 3'd0,
        REQ_LINE   = 3'd1,
        REQ_SCRX   = 3'd2,
        REQ_SCRY   = 3'd3,
        REQ_READ   = 3'd4,
        REQ_FLUSH  = 3'd5,
        REQ_NOP6   = 3'd6,
        REQ_NOP7   = 3'd7
    } t_req;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] box_width;
        logic signed [15:0] box_height;
        logic signed [15:0] scroll_offset;
        logic [31:0]        pixel_color;
    } t_cmd;

    typedef struct packed {
        logic [31:0] read_value;
        logic        region_valid;
        logic [7:0]  region_min_x;
        logic [7:0]  region_min_y;
        logic [7:0]  region_max_x;
        logic [7:0]  region_max_y;
    } t_res;

endpackage

// ----- rtl/bde_cmd_if.sv -----
// Request and result channel interfaces of the bitmap draw engine.
// Depends on bde_pkg for the payload types.
interface bde_cmd_if;
    logic          valid;
    logic          ready;
    bde_pkg::t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bde_res_if;
    logic          valid;
    logic          ready;
    bde_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/bde_ram.sv -----
// Generic single-port write, single-port read RAM with a registered read.
// Depends on nothing.
module bde_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/bde_front.sv -----
// Front end: accepts requests into a short queue ahead of the execution engine.
// Depends on bde_pkg and the request channel interface.
module bde_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bde_cmd_if.sink       s_in,
    output logic          o_valid,
    output bde_pkg::t_cmd o_cmd,
    input  logic          i_take
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    bde_pkg::t_cmd r_q [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          push, pop;

    assign s_in.ready = (r_cnt != (AW+1)'(DEPTH));
    assign push = s_in.valid && s_in.ready;
    assign o_valid = (r_cnt != '0);
    assign pop = o_valid && i_take;
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= s_in.data;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ----- rtl/bde_div.sv -----
// Restoring divider for the line slope, one quotient bit per cycle.
// Depends on nothing.
module bde_div #(
    parameter int unsigned NW = 40,
    parameter int unsigned DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int unsigned CW = $clog2(NW + 1);
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   trial;

    assign trial = {r_rem[DW-1:0], r_q[NW-1]};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= CW'(NW);
            end else if (r_busy) begin
                if (trial >= {1'b0, r_den}) begin
                    r_rem <= trial - {1'b0, r_den};
                    r_q <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_q <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- rtl/bde_engine.sv -----
// Back end: executes one queued command on the frame store and produces one result.
// Depends on bde_pkg, bde_ram, bde_div and the result interface.
module bde_engine #(
    parameter int unsigned MAX_WIDTH = 256,
    parameter int unsigned MAX_HEIGHT = 256,
    parameter int unsigned SLOPE_FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  bde_pkg::t_cmd             i_cmd,
    output logic                      o_take,
    input  logic [bde_pkg::RegW-1:0]  i_fw,
    input  logic [bde_pkg::RegW-1:0]  i_fh,
    bde_res_if.source                 m_out
);
    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned XW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned YW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned F = SLOPE_FRAC_BITS;
    localparam int unsigned NW = 17 + F;
    localparam int unsigned SW = 18 + F;
    localparam int unsigned AccW = SW + 20;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_DECODE, S_FILL, S_DIV, S_WALK, S_SCRD, S_SCRW,
        S_RDWAIT, S_RDDONE, S_OUT
    } t_state;

    t_state r_state;
    bde_pkg::t_cmd r_cmd;
    bde_pkg::t_res r_res;
    logic          r_ovalid;
    logic          r_dp;
    logic signed [17:0] r_dlx, r_dly, r_dhx, r_dhy;

    logic signed [17:0] r_x0, r_x1, r_y0, r_y1, r_i, r_j;
    logic [31:0]        r_col;
    logic               r_xmaj, r_neg;
    logic signed [17:0] r_a0, r_a1, r_b0;
    logic signed [SW-1:0] r_slope;
    logic signed [AccW-1:0] r_acc;
    logic               r_pend;
    logic [AW:0]        r_clr;

    logic [XW-1:0] ew;
    logic [YW-1:0] eh;
    logic signed [17:0] w18, h18;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_q;
    logic [16:0]   div_den;

    bde_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    bde_div #(.NW(NW), .DW(17)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .o_done(div_done), .o_quot(div_q)
    );

    always_comb begin
        if (i_fw == '0) begin
            ew = XW'(1);
        end else if ({23'd0, i_fw} > 32'(MAX_WIDTH)) begin
            ew = XW'(MAX_WIDTH);
        end else begin
            ew = XW'(i_fw);
        end
        if (i_fh == '0) begin
            eh = YW'(1);
        end else if ({23'd0, i_fh} > 32'(MAX_HEIGHT)) begin
            eh = YW'(MAX_HEIGHT);
        end else begin
            eh = YW'(i_fh);
        end
    end
    assign w18 = 18'(ew);
    assign h18 = 18'(eh);

    function automatic logic [AW-1:0] addr_of(input logic signed [17:0] x,
                                              input logic signed [17:0] y,
                                              input logic signed [17:0] w);
        logic [35:0] p;
        p = 36'(y[16:0]) * 36'(w[16:0]) + 36'(x[16:0]);
        return p[AW-1:0];
    endfunction

    // Line walk: current major k = r_i, minor from accumulator floor.
    logic signed [AccW-1:0] mval;
    logic signed [17:0] lx, ly;
    logic               lin;
    assign mval = r_acc >>> F;
    always_comb begin
        if (r_xmaj) begin
            lx = r_i;
            ly = 18'(mval);
        end else begin
            lx = 18'(mval);
            ly = r_i;
        end
        lin = (mval >= -AccW'(1)) && (mval <= AccW'(65536)) &&
              lx >= 0 && ly >= 0 && lx < w18 && ly < h18;
    end

    // Scroll source coordinate for current destination (r_i, r_j).
    logic signed [17:0] sof, srcx, srcy;
    logic               sfill;
    assign sof = 18'(r_cmd.scroll_offset);
    always_comb begin
        srcx = r_i;
        srcy = r_j;
        if (r_cmd.req_type == bde_pkg::REQ_SCRX) begin
            srcx = r_i - sof;
        end else begin
            srcy = r_j - sof;
        end
        sfill = srcx < 0 || srcx >= w18 || srcy < 0 || srcy >= h18;
    end

    // Dirty rectangle update helper inputs.
    logic               dadd;
    logic signed [17:0] dax0, day0, dax1, day1;
    logic               dall, dclr;

    logic signed [17:0] sx, sy, ex, ey, bw, bh, bx, by;
    logic signed [17:0] adx, ady, dx, dy, absoff;
    assign sx = 18'(r_cmd.start_x);
    assign sy = 18'(r_cmd.start_y);
    assign ex = 18'(r_cmd.end_x);
    assign ey = 18'(r_cmd.end_y);
    assign dx = ex - sx;
    assign dy = ey - sy;
    assign adx = dx[17] ? -dx : dx;
    assign ady = dy[17] ? -dy : dy;
    assign absoff = sof[17] ? -sof : sof;

    logic [1:0] r_step;

    always_comb begin
        bx = sx;
        by = sy;
        bw = 18'(r_cmd.box_width);
        bh = 18'(r_cmd.box_height);
        if (bx < 0) begin
            bw = bw + bx;
            bx = '0;
        end
        if (by < 0) begin
            bh = bh + by;
            by = '0;
        end
        if (bx + bw >= w18) begin
            bw = w18 - bx;
        end
        if (by + bh >= h18) begin
            bh = h18 - by;
        end
    end

    logic box_out;
    assign box_out = (sx + 18'(r_cmd.box_width) < 0) || sx >= w18 ||
                     (sy + 18'(r_cmd.box_height) < 0) || sy >= h18;

    logic rd_in;
    assign rd_in = sx >= 0 && sy >= 0 && sx < w18 && sy < h18;

    assign o_take = (r_state == S_IDLE) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.data = r_res;

    always_comb begin
        we = 1'b0;
        waddr = addr_of(r_i, r_j, w18);
        wdata = r_col;
        raddr = addr_of(srcx, srcy, w18);
        div_start = 1'b0;
        div_num = '0;
        div_den = '0;
        dadd = 1'b0;
        dax0 = '0;
        day0 = '0;
        dax1 = '0;
        day1 = '0;
        dall = 1'b0;
        dclr = 1'b0;
        case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                waddr = r_clr[AW-1:0];
                wdata = '0;
            end
            S_DECODE: begin
                raddr = addr_of(sx, sy, w18);
                case (r_cmd.req_type)
                    bde_pkg::REQ_BOX: begin
                        dadd = !box_out;
                        dax0 = bx;
                        day0 = by;
                        dax1 = bx + bw - 18'sd1;
                        day1 = by + bh - 18'sd1;
                    end
                    bde_pkg::REQ_LINE: begin
                        dadd = 1'b1;
                        dax0 = sx;
                        day0 = sy;
                        dax1 = ex;
                        day1 = ey;
                        div_start = (adx != 0) || (ady != 0);
                        if (adx > ady) begin
                            div_num = {ady[16:0], F'(0)};
                            div_den = adx[16:0];
                        end else begin
                            div_num = {adx[16:0], F'(0)};
                            div_den = ady[16:0];
                        end
                    end
                    bde_pkg::REQ_SCRX, bde_pkg::REQ_SCRY: begin
                        dall = (absoff != 0);
                    end
                    bde_pkg::REQ_FLUSH: begin
                        dclr = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_FILL: begin
                we = 1'b1;
            end
            S_WALK: begin
                we = r_step == 2'd1 && lin;
                waddr = addr_of(lx, ly, w18);
            end
            S_SCRW: begin
                we = 1'b1;
                waddr = addr_of(r_x0, r_y0, w18);
                wdata = r_pend ? r_col : rdata;
            end
            S_RDWAIT: begin
                raddr = addr_of(sx, sy, w18);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_dp <= 1'b1;
            r_dlx <= '0;
            r_dly <= '0;
            r_dhx <= 18'sd255;
            r_dhy <= 18'sd255;
            r_step <= '0;
        end else begin
            if (m_out.valid && m_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (dadd) begin
                if (!r_dp) begin
                    r_dlx <= (dax1 < dax0) ? dax1 : dax0;
                    r_dhx <= (dax1 > dax0) ? dax1 : dax0;
                    r_dly <= (day1 < day0) ? day1 : day0;
                    r_dhy <= (day1 > day0) ? day1 : day0;
                end else begin
                    r_dlx <= (dax1 < r_dlx && dax1 < dax0) ? dax1 :
                             (dax0 < r_dlx) ? dax0 : r_dlx;
                    r_dhx <= (dax1 > r_dhx && dax1 > dax0) ? dax1 :
                             (dax0 > r_dhx) ? dax0 : r_dhx;
                    r_dly <= (day1 < r_dly && day1 < day0) ? day1 :
                             (day0 < r_dly) ? day0 : r_dly;
                    r_dhy <= (day1 > r_dhy && day1 > day0) ? day1 :
                             (day0 > r_dhy) ? day0 : r_dhy;
                end
                r_dp <= 1'b1;
            end
            if (dall) begin
                r_dp <= 1'b1;
                r_dlx <= '0;
                r_dly <= '0;
                r_dhx <= w18 - 18'sd1;
                r_dhy <= h18 - 18'sd1;
            end
            if (dclr) begin
                r_dp <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && !r_ovalid) begin
                        r_cmd <= i_cmd;
                        r_col <= i_cmd.pixel_color;
                        r_res <= '0;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (r_cmd.req_type)
                        bde_pkg::REQ_BOX: begin
                            r_i <= bx;
                            r_j <= by;
                            r_x0 <= bx;
                            r_x1 <= bx + bw - 18'sd1;
                            r_y1 <= by + bh - 18'sd1;
                            r_state <= (!box_out && bw > 0 && bh > 0) ? S_FILL : S_OUT;
                        end
                        bde_pkg::REQ_LINE: begin
                            r_xmaj <= adx > ady;
                            if (adx > ady) begin
                                r_neg <= dx[17] != dy[17];
                                r_a0 <= dx[17] ? ex : sx;
                                r_a1 <= dx[17] ? sx : ex;
                                r_b0 <= dx[17] ? ey : sy;
                                r_state <= S_DIV;
                            end else if (dy != 0) begin
                                r_neg <= dx[17] != dy[17];
                                r_a0 <= dy[17] ? ey : sy;
                                r_a1 <= dy[17] ? sy : ey;
                                r_b0 <= dy[17] ? ex : sx;
                                r_state <= S_DIV;
                            end else begin
                                r_i <= sx;
                                r_j <= sy;
                                r_state <= (rd_in) ? S_FILL : S_OUT;
                                r_x0 <= sx;
                                r_x1 <= sx;
                                r_y1 <= sy;
                            end
                        end
                        bde_pkg::REQ_SCRX, bde_pkg::REQ_SCRY: begin
                            if (absoff == 0) begin
                                r_state <= S_OUT;
                            end else begin
                                r_i <= (sof > 0) ? w18 - 18'sd1 : '0;
                                r_j <= (sof > 0) ? h18 - 18'sd1 : '0;
                                r_state <= S_SCRD;
                            end
                        end
                        bde_pkg::REQ_READ: begin
                            r_state <= rd_in ? S_RDWAIT : S_OUT;
                        end
                        bde_pkg::REQ_FLUSH: begin
                            if (r_dp && r_dhx >= 0 && r_dhy >= 0 &&
                                r_dlx < w18 && r_dly < h18) begin
                                r_res.region_valid <= 1'b1;
                                r_res.region_min_x <= r_dlx[17] ? 8'd0 : r_dlx[7:0];
                                r_res.region_min_y <= r_dly[17] ? 8'd0 : r_dly[7:0];
                                r_res.region_max_x <= (r_dhx >= w18) ?
                                                      8'(w18 - 18'sd1) : r_dhx[7:0];
                                r_res.region_max_y <= (r_dhy >= h18) ?
                                                      8'(h18 - 18'sd1) : r_dhy[7:0];
                            end
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_FILL: begin
                    if (r_i >= r_x1) begin
                        r_i <= r_x0;
                        if (r_j >= r_y1) begin
                            r_state <= S_OUT;
                        end else begin
                            r_j <= r_j + 18'sd1;
                        end
                    end else begin
                        r_i <= r_i + 18'sd1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_slope <= r_neg ? -SW'(div_q) : SW'(div_q);
                        r_i <= (r_a0 < 0) ? '0 : r_a0;
                        r_a1 <= (r_a1 > ((r_xmaj ? w18 : h18) - 18'sd1)) ?
                                (r_xmaj ? w18 : h18) - 18'sd1 : r_a1;
                        r_step <= 2'd0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_step == 2'd0) begin
                        r_acc <= (AccW'(r_b0) <<< F) + AccW'(1 << (F - 1)) +
                                 AccW'(r_i - r_a0) * AccW'(r_slope);
                        r_step <= 2'd1;
                        if (r_i > r_a1) begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_i <= r_i + 18'sd1;
                        r_step <= 2'd0;
                    end
                end
                S_SCRD: begin
                    r_x0 <= r_i;
                    r_y0 <= r_j;
                    r_pend <= sfill || absoff >= ((r_cmd.req_type == bde_pkg::REQ_SCRX)
                                                  ? w18 : h18);
                    r_state <= S_SCRW;
                end
                S_SCRW: begin
                    r_state <= S_SCRD;
                    if (sof > 0) begin
                        if (r_i == 0) begin
                            r_i <= w18 - 18'sd1;
                            if (r_j == 0) begin
                                r_state <= S_OUT;
                            end else begin
                                r_j <= r_j - 18'sd1;
                            end
                        end else begin
                            r_i <= r_i - 18'sd1;
                        end
                    end else begin
                        if (r_i == w18 - 18'sd1) begin
                            r_i <= '0;
                            if (r_j == h18 - 18'sd1) begin
                                r_state <= S_OUT;
                            end else begin
                                r_j <= r_j + 18'sd1;
                            end
                        end else begin
                            r_i <= r_i + 18'sd1;
                        end
                    end
                end
                S_RDWAIT: begin
                    r_state <= S_RDDONE;
                end
                S_RDDONE: begin
                    r_res.read_value <= rdata;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- rtl/bitmap_draw_engine.sv -----
// Top level of the bitmap draw engine: request queue, execution engine, size registers.
// Depends on bde_pkg, the channel interfaces, bde_front and bde_engine.
//
// Requests enter on s_req (valid/ready) and each yields exactly one result on
// m_res. A two-entry queue takes requests while the engine works. A flush, an
// unused code, a zero scroll or a box outside the frame goes straight to its
// result; a read first waits for the registered frame RAM read; a box fill
// writes its pixels one at a time; a line of more than one point runs the slope
// divider, then takes a compute step and a write step per major step; a scroll
// reads and then writes every frame pixel, since each pixel needs a read and a
// write on the single frame RAM port pair.
// After reset the engine clears all MAX_WIDTH*MAX_HEIGHT pixels of the frame
// store one pixel a cycle and takes no request until done; size register
// writes are taken at any time. When the receiver stalls, the result stays
// registered and the engine waits before starting the next request.
module bitmap_draw_engine #(
    parameter int unsigned MAX_WIDTH = 256,
    parameter int unsigned MAX_HEIGHT = 256,
    parameter int unsigned SLOPE_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bde_cmd_if.sink     s_req,
    bde_res_if.source   m_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    logic [8:0] r_fw, r_fh;
    logic          q_valid, q_take;
    bde_pkg::t_cmd q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 9'd256;
            r_fh <= 9'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_index) begin
                r_fh <= i_cfg_data;
            end else begin
                r_fw <= i_cfg_data;
            end
        end
    end

    bde_front #(.DEPTH(2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_req),
        .o_valid(q_valid), .o_cmd(q_cmd), .i_take(q_take)
    );

    bde_engine #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
    ) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(q_cmd),
        .o_take(q_take), .i_fw(r_fw), .i_fh(r_fh), .m_out(m_res)
    );
endmodule

// ----- test/bitmap_draw_engine_test.sv -----
// Self-checking testbench for bitmap_draw_engine: directed and random requests, random stalls.
// Uses bde_pkg, both interfaces, bitmap_draw_engine; predicts results with its own frame model.
`timescale 1ns / 100ps

module bitmap_draw_engine_test;

    localparam int          CycleLimit = 30000000;
    localparam int          RandomItems = 1925;
    localparam bit          REG_WIDTH = 1'b0;
    localparam bit          REG_HEIGHT = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [8:0]  cfg_data = '0;

    bde_cmd_if req_ch ();
    bde_res_if res_ch ();

    bitmap_draw_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_req      (req_ch.sink),
        .m_res      (res_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    logic [31:0] pixel_mem [0:65535];
    bit          dirty_on;
    int          dirty_x0, dirty_y0, dirty_x1, dirty_y1;
    logic [8:0]  size_w, size_h;

    bde_pkg::t_res pending_q[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          requests_sent = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          rx_quiet = 1'b0;
    int          rx_hold = 0;

    always #1 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    function automatic int width_used();
        if (size_w < 1) return 1;
        if (size_w > 256) return 256;
        return int'(size_w);
    endfunction

    function automatic int height_used();
        if (size_h < 1) return 1;
        if (size_h > 256) return 256;
        return int'(size_h);
    endfunction

    function automatic void grow_dirty(int x, int y);
        if (!dirty_on) begin
            dirty_on = 1'b1;
            dirty_x0 = x;
            dirty_x1 = x;
            dirty_y0 = y;
            dirty_y1 = y;
        end else begin
            if (x < dirty_x0) dirty_x0 = x;
            if (x > dirty_x1) dirty_x1 = x;
            if (y < dirty_y0) dirty_y0 = y;
            if (y > dirty_y1) dirty_y1 = y;
        end
    endfunction

    function automatic void plot(int x, int y, logic [31:0] c);
        int w;
        int h;
        w = width_used();
        h = height_used();
        if (x >= 0 && y >= 0 && x < w && y < h) pixel_mem[y * w + x] = c;
    endfunction

    function automatic void paint(int x, int y, int sw, int sh, logic [31:0] c);
        int w;
        w = width_used();
        for (int j = 0; j < sh; j++)
            for (int i = 0; i < sw; i++)
                pixel_mem[(y + j) * w + x + i] = c;
    endfunction

    function automatic void draw_box(int x, int y, int sw, int sh, logic [31:0] c);
        int w;
        int h;
        w = width_used();
        h = height_used();
        if (x + sw < 0 || x >= w || y + sh < 0 || y >= h) return;
        if (x < 0) begin
            sw += x;
            x = 0;
        end
        if (y < 0) begin
            sh += y;
            y = 0;
        end
        if (x + sw >= w) sw = w - x;
        if (y + sh >= h) sh = h - y;
        grow_dirty(x, y);
        grow_dirty(x + sw - 1, y + sh - 1);
        if (sw > 0 && sh > 0) paint(x, y, sw, sh, c);
    endfunction

    function automatic void trace_axis(int a0, int a1, int b0, longint slope, bit x_major,
                                       logic [31:0] c);
        int     lim;
        int     k;
        int     last;
        longint acc;
        longint m;
        lim = x_major ? width_used() : height_used();
        k = (a0 < 0) ? 0 : a0;
        last = (a1 > lim - 1) ? lim - 1 : a1;
        for (; k <= last; k++) begin
            acc = longint'(b0) * 65536 + longint'(k - a0) * slope + 32768;
            m = acc >>> 16;
            if (m < -1 || m > 65536) continue;
            if (x_major) plot(k, int'(m), c);
            else plot(int'(m), k, c);
        end
    endfunction

    function automatic longint line_slope(int dmin, int dmaj);
        longint q;
        q = ((dmin < 0 ? -longint'(dmin) : longint'(dmin)) * 65536)
            / (dmaj < 0 ? -longint'(dmaj) : longint'(dmaj));
        return ((dmin < 0) != (dmaj < 0)) ? -q : q;
    endfunction

    function automatic void draw_line(int sx, int sy, int ex, int ey, logic [31:0] c);
        int dx;
        int dy;
        dx = ex - sx;
        dy = ey - sy;
        if ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy)) begin
            if (dx < 0) trace_axis(ex, sx, ey, line_slope(dy, dx), 1'b1, c);
            else trace_axis(sx, ex, sy, line_slope(dy, dx), 1'b1, c);
        end else if (dy != 0) begin
            if (dy < 0) trace_axis(ey, sy, ex, line_slope(dx, dy), 1'b0, c);
            else trace_axis(sy, ey, sx, line_slope(dx, dy), 1'b0, c);
        end else begin
            plot(sx, sy, c);
        end
        grow_dirty(sx, sy);
        grow_dirty(ex, ey);
    endfunction

    function automatic void shift_frame(int off, bit horiz, logic [31:0] c);
        int w;
        int h;
        int n;
        int count;
        w = width_used();
        h = height_used();
        n = (off < 0) ? -off : off;
        if (n >= (horiz ? w : h)) begin
            paint(0, 0, w, h, c);
        end else if (off == 0) begin
            return;
        end else if (horiz) begin
            for (int r = 0; r < h; r++) begin
                if (off > 0)
                    for (int i = w - 1; i >= n; i--)
                        pixel_mem[r * w + i] = pixel_mem[r * w + i - n];
                else
                    for (int i = 0; i < w - n; i++)
                        pixel_mem[r * w + i] = pixel_mem[r * w + i + n];
            end
            paint(off > 0 ? 0 : w - n, 0, n, h, c);
        end else begin
            count = w * (h - n);
            if (off > 0)
                for (int i = count - 1; i >= 0; i--) pixel_mem[n * w + i] = pixel_mem[i];
            else
                for (int i = 0; i < count; i++) pixel_mem[i] = pixel_mem[i + n * w];
            paint(0, off > 0 ? 0 : h - n, w, n, c);
        end
        dirty_on = 1'b1;
        dirty_x0 = 0;
        dirty_y0 = 0;
        dirty_x1 = w - 1;
        dirty_y1 = h - 1;
    endfunction

    function automatic bde_pkg::t_res apply_request(bde_pkg::t_cmd c);
        bde_pkg::t_res r;
        int   w;
        int   h;
        int   sx;
        int   sy;
        r = '0;
        w = width_used();
        h = height_used();
        sx = c.start_x;
        sy = c.start_y;
        case (bde_pkg::t_req'(c.req_type))
            bde_pkg::REQ_BOX:  draw_box(sx, sy, c.box_width, c.box_height, c.pixel_color);
            bde_pkg::REQ_LINE: draw_line(sx, sy, c.end_x, c.end_y, c.pixel_color);
            bde_pkg::REQ_SCRX: shift_frame(c.scroll_offset, 1'b1, c.pixel_color);
            bde_pkg::REQ_SCRY: shift_frame(c.scroll_offset, 1'b0, c.pixel_color);
            bde_pkg::REQ_READ: begin
                if (sx >= 0 && sy >= 0 && sx < w && sy < h)
                    r.read_value = pixel_mem[sy * w + sx];
            end
            bde_pkg::REQ_FLUSH: begin
                if (dirty_on && dirty_x1 >= 0 && dirty_y1 >= 0 &&
                    dirty_x0 < w && dirty_y0 < h) begin
                    r.region_valid = 1'b1;
                    r.region_min_x = 8'((dirty_x0 < 0) ? 0 : dirty_x0);
                    r.region_min_y = 8'((dirty_y0 < 0) ? 0 : dirty_y0);
                    r.region_max_x = 8'((dirty_x1 >= w) ? w - 1 : dirty_x1);
                    r.region_max_y = 8'((dirty_y1 >= h) ? h - 1 : dirty_y1);
                end
                dirty_on = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(input bde_pkg::t_cmd c);
        if (!calm && $urandom_range(0, 9) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        pending_q.push_back(apply_request(c));
        requests_sent++;
        req_ch.valid <= 1'b1;
        req_ch.data <= c;
        forever begin
            @(negedge i_clk);
            if (req_ch.ready) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_frame_size(input logic [8:0] w, input logic [8:0] h);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data <= w;
        size_w = w;
        @(posedge i_clk);
        cfg_index <= REG_HEIGHT;
        cfg_data <= h;
        size_h = h;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic bde_pkg::t_cmd make_cmd(bde_pkg::t_req op, int sx, int sy, int ex,
                                               int ey, int bw, int bh, int off,
                                               logic [31:0] color);
        bde_pkg::t_cmd c;
        c.req_type = op;
        c.start_x = 16'(sx);
        c.start_y = 16'(sy);
        c.end_x = 16'(ex);
        c.end_y = 16'(ey);
        c.box_width = 16'(bw);
        c.box_height = 16'(bh);
        c.scroll_offset = 16'(off);
        c.pixel_color = color;
        return c;
    endfunction

    function automatic int near_coord(int lim);
        if ($urandom_range(0, 99) == 0) return int'($signed(16'($urandom())));
        return $urandom_range(0, lim + 7) - 4;
    endfunction

    function automatic bde_pkg::t_cmd random_cmd();
        bde_pkg::t_cmd c;
        int   pick;
        int   w;
        int   h;
        w = width_used();
        h = height_used();
        c = make_cmd(bde_pkg::REQ_BOX, near_coord(w), near_coord(h), near_coord(w),
                     near_coord(h), near_coord(w), near_coord(h), 0, $urandom());
        c.scroll_offset = ($urandom_range(0, 9) == 0) ? 16'($urandom())
                                                      : 16'($urandom_range(0, 2 * w) - w);
        pick = $urandom_range(0, 99);
        if (pick < 22) c.req_type = bde_pkg::REQ_BOX;
        else if (pick < 44) c.req_type = bde_pkg::REQ_LINE;
        else if (pick < 50) c.req_type = bde_pkg::REQ_SCRX;
        else if (pick < 56) c.req_type = bde_pkg::REQ_SCRY;
        else if (pick < 84) c.req_type = bde_pkg::REQ_READ;
        else if (pick < 96) c.req_type = bde_pkg::REQ_FLUSH;
        else c.req_type = ($urandom_range(0, 1) != 0) ? bde_pkg::REQ_NOP6 : bde_pkg::REQ_NOP7;
        return c;
    endfunction

    task automatic test_reset_state();
        send_request(make_cmd(bde_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0, '0));
        send_request(make_cmd(bde_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, '0));
        send_request(make_cmd(bde_pkg::REQ_READ, -1, 0, 0, 0, 0, 0, 0, '0));
        send_request(make_cmd(bde_pkg::REQ_READ, 256, 3, 0, 0, 0, 0, 0, '0));
    endtask

    task automatic test_boxes();
        send_request(make_cmd(bde_pkg::REQ_BOX, -32768, 0, 0, 0, 32767, 4, 0, 32'hFFFF_FFFF));
        send_request(make_cmd(bde_pkg::REQ_BOX, -3, -2, 0, 0, 6, 5, 0, 32'h1122_3344));
        send_request(make_cmd(bde_pkg::REQ_BOX, 10, 10, 0, 0, 0, 3, 0, 32'h5566_7788));
        send_request(make_cmd(bde_pkg::REQ_BOX, 250, 250, 0, 0, 32767, 32767, 0,
                              32'h8000_0001));
        send_request(make_cmd(bde_pkg::REQ_BOX, 32767, 2, 0, 0, -32768, 2, 0, 32'hDEAD_BEEF));
    endtask

    task automatic test_lines();
        send_request(make_cmd(bde_pkg::REQ_LINE, 5, 5, 5, 5, 0, 0, 0, 32'hA5A5_A5A5));
        send_request(make_cmd(bde_pkg::REQ_LINE, 3, 0, 5, 20, 0, 0, 0, 32'h0F0F_0F0F));
        send_request(make_cmd(bde_pkg::REQ_LINE, 40, 9, 0, 2, 0, 0, 0, 32'hF0F0_F0F0));
        send_request(make_cmd(bde_pkg::REQ_LINE, -32768, 7, 32767, 7, 0, 0, 0, 32'h7FFF_FFFF));
        send_request(make_cmd(bde_pkg::REQ_READ, 4, 10, 0, 0, 0, 0, 0, '0));
        send_request(make_cmd(bde_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0, '0));
        send_request(make_cmd(bde_pkg::REQ_NOP6, 1, 1, 1, 1, 1, 1, 1, 32'h1));
        send_request(make_cmd(bde_pkg::REQ_NOP7, -1, -1, -1, -1, -1, -1, -1, 32'hFFFF_FFFF));
    endtask

    task automatic test_scrolls();
        set_frame_size(9'd256, 9'd2);
        send_request(make_cmd(bde_pkg::REQ_SCRX, 0, 0, 0, 0, 0, 0, 3, 32'h0102_0304));
        send_request(make_cmd(bde_pkg::REQ_SCRX, 0, 0, 0, 0, 0, 0, -5, 32'h0506_0708));
        send_request(make_cmd(bde_pkg::REQ_SCRX, 0, 0, 0, 0, 0, 0, 0, 32'h0A0B_0C0D));
        send_request(make_cmd(bde_pkg::REQ_SCRX, 0, 0, 0, 0, 0, 0, 32767, 32'h0E0F_1011));
        send_request(make_cmd(bde_pkg::REQ_SCRY, 0, 0, 0, 0, 0, 0, 1, 32'h1213_1415));
        send_request(make_cmd(bde_pkg::REQ_SCRY, 0, 0, 0, 0, 0, 0, -32768, 32'h1617_1819));
        send_request(make_cmd(bde_pkg::REQ_READ, 255, 1, 0, 0, 0, 0, 0, '0));
        send_request(make_cmd(bde_pkg::REQ_FLUSH, 0, 0, 0, 0, 0, 0, 0, '0));
    endtask

    task automatic test_random_traffic();
        int          done_items;
        int          kind;
        logic [8:0]  w;
        logic [8:0]  h;
        done_items = 0;
        while (done_items < RandomItems) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                w = 9'($urandom_range(1, 24));
                h = 9'($urandom_range(1, 24));
            end else if (kind == 7) begin
                w = 9'(($urandom_range(0, 1) != 0) ? 511 : $urandom_range(0, 1) * 256);
                h = 9'($urandom_range(1, 2));
            end else if (kind == 8) begin
                w = 9'($urandom_range(1, 2));
                h = 9'(($urandom_range(0, 1) != 0) ? 300 : $urandom_range(0, 1) * 256);
            end else begin
                w = 9'($urandom_range(25, 40));
                h = 9'($urandom_range(25, 40));
            end
            set_frame_size(w, h);
            if (done_items > RandomItems - 200) calm = 1'b1;
            for (int i = 0; i < 60 && done_items < RandomItems; i++) begin
                if (i == 30 && $urandom_range(0, 3) == 0) drain_results();
                send_request(random_cmd());
                done_items++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || calm || rx_quiet) begin
            res_ch.ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            res_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            rx_hold <= $urandom_range(0, 18);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
        if ($urandom_range(0, 299) == 0) rx_quiet <= ~rx_quiet;
    end

    always @(negedge i_clk) begin
        bde_pkg::t_res want;
        bde_pkg::t_res got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            results_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_q.pop_front();
                if (got.read_value !== want.read_value
                    || got.region_valid !== want.region_valid
                    || got.region_min_x !== want.region_min_x
                    || got.region_min_y !== want.region_min_y
                    || got.region_max_x !== want.region_max_x
                    || got.region_max_y !== want.region_max_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected read %h region %b %0d,%0d..%0d,%0d;",
                                  " got read %h region %b %0d,%0d..%0d,%0d"},
                                 results_seen, want.read_value, want.region_valid,
                                 want.region_min_x, want.region_min_y, want.region_max_x,
                                 want.region_max_y, got.read_value, got.region_valid,
                                 got.region_min_x, got.region_min_y, got.region_max_x,
                                 got.region_max_y);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
            $display("bitmap_draw_engine_test NOT OK");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 65536; i++) pixel_mem[i] = '0;
        size_w = 9'd256;
        size_h = 9'd256;
        dirty_on = 1'b1;
        dirty_x0 = 0;
        dirty_y0 = 0;
        dirty_x1 = 255;
        dirty_y1 = 255;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_boxes();
        test_lines();
        test_scrolls();
        test_random_traffic();
        drain_results();
        repeat (50) @(posedge i_clk);
        $display("%0d requests sent and %0d results checked over frame sizes from 1x1 to 256x256,",
                 requests_sent, results_seen);
        $display("covering boxes, lines, scrolls, reads, flushes and unused codes; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("bitmap_draw_engine_test OK");
        end else begin
            $display("bitmap_draw_engine_test NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bde_pkg.sv
rtl/bde_cmd_if.sv
rtl/bde_ram.sv
rtl/bde_front.sv
rtl/bde_div.sv
rtl/bde_engine.sv
rtl/bitmap_draw_engine.sv
test/bitmap_draw_engine_test.sv
